// File: sv/hcodec_pkg.sv
// ----------------------------------------------------------------------------
// hcodec_pkg
// Shared types, constants and Hamming(12,8) parity functions for the codec.
// ----------------------------------------------------------------------------
package hcodec_pkg;

  localparam int HC_QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2,
    PH_SPARE  = 2'd3
  } phase_t;

  // One queued transaction: one or two results from a single input byte.
  typedef struct packed {
    logic [7:0] byte0;
    logic       bad0;
    logic       last0;
    logic       two;
    logic [7:0] byte1;
    logic       last1;
  } job_t;

  // Data bit k (MSB first) sits at codeword position given here.
  localparam logic [3:0] DATA_POS [8] = '{4'd3, 4'd5, 4'd6, 4'd7,
                                          4'd9, 4'd10, 4'd11, 4'd12};

  // Position p (1..12) lives at vector bit 12 - p.
  function automatic logic [3:0] syndrome(input logic [11:0] w);
    logic [3:0] s;
    s = '0;
    for (int p = 1; p <= 12; p++) begin
      if (w[12 - p]) s = s ^ 4'(p);
    end
    return s;
  endfunction

  function automatic logic [11:0] encode_word(input logic [7:0] d);
    logic [11:0] w;
    logic [3:0]  s;
    w = '0;
    for (int k = 0; k < 8; k++) begin
      w[12 - 32'(DATA_POS[k])] = d[7 - k];
    end
    s = syndrome(w);
    w[11] = s[0];
    w[10] = s[1];
    w[8]  = s[2];
    w[4]  = s[3];
    return w;
  endfunction

  // Returns {bad, data}.
  function automatic logic [8:0] decode_word(input logic [11:0] w_in);
    logic [11:0] w;
    logic [3:0]  s;
    logic [7:0]  d;
    w = w_in;
    s = syndrome(w_in);
    d = '0;
    if (s > 4'd12) begin
      return {1'b1, 8'h00};
    end
    if (s != 4'd0) w[12 - 32'(s)] = ~w[12 - 32'(s)];
    for (int k = 0; k < 8; k++) begin
      d[7 - k] = w[12 - 32'(DATA_POS[k])];
    end
    return {1'b0, d};
  endfunction

endpackage

// File: sv/hcodec_front.sv
// ----------------------------------------------------------------------------
// hcodec_front
// Accepts input bytes, tracks the 3-byte packing phase and forms the results
// of each byte as a queued transaction.
// ----------------------------------------------------------------------------
module hcodec_front
  import hcodec_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       direction_we,
  input  logic       direction_data,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       job_push,
  output job_t       job
);

  logic       direction;
  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] held;
  logic [7:0] held_next;
  logic       has_result;
  logic [11:0] enc_w;
  logic [11:0] dec_w;
  logic [8:0]  dec_r;

  assign enc_w = encode_word(in_byte);
  assign dec_w = (phase == PH_THIRD) ? {held[3:0], in_byte} : {held, in_byte[7:4]};
  assign dec_r = decode_word(dec_w);

  always_comb begin
    job        = '0;
    has_result = 1'b0;
    phase_next = PH_FIRST;
    held_next  = '0;
    if (!direction) begin
      has_result = 1'b1;
      if (phase != PH_SECOND) begin
        job.byte0 = enc_w[11:4];
        if (in_last) begin
          job.two   = 1'b1;
          job.byte1 = {enc_w[3:0], 4'h0};
          job.last1 = 1'b1;
        end else begin
          phase_next = PH_SECOND;
          held_next  = {4'h0, enc_w[3:0]};
        end
      end else begin
        job.byte0 = {held[3:0], enc_w[11:8]};
        job.two   = 1'b1;
        job.byte1 = enc_w[7:0];
        job.last1 = in_last;
      end
    end else begin
      case (phase)
        PH_SECOND: begin
          has_result = 1'b1;
          job.byte0  = dec_r[7:0];
          job.bad0   = dec_r[8];
          job.last0  = in_last;
          if (!in_last) begin
            phase_next = PH_THIRD;
            held_next  = {4'h0, in_byte[3:0]};
          end
        end
        PH_THIRD: begin
          has_result = 1'b1;
          job.byte0  = dec_r[7:0];
          job.bad0   = dec_r[8];
          job.last0  = in_last;
        end
        default: begin
          if (!in_last) begin
            phase_next = PH_SECOND;
            held_next  = in_byte;
          end
        end
      endcase
    end
  end

  assign job_push = accept && has_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= 1'b0;
      phase     <= PH_FIRST;
      held      <= '0;
    end else if (direction_we) begin
      direction <= direction_data;
      phase     <= PH_FIRST;
      held      <= '0;
    end else if (accept) begin
      phase <= phase_next;
      held  <= held_next;
    end
  end

endmodule

// File: sv/hcodec_queue.sv
// ----------------------------------------------------------------------------
// hcodec_queue
// Short transaction queue between the front and back parts.
// ----------------------------------------------------------------------------
module hcodec_queue
  import hcodec_pkg::*;
#(
  parameter int DEPTH = HC_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  job_t wr_job,
  input  logic rd_en,
  output job_t rd_job,
  output logic full,
  output logic empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  job_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full   = (count == CW'(DEPTH));
  assign empty  = (count == '0);
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + AW'(1);
      if (do_rd) rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + AW'(1);
      if (do_wr && !do_rd) count <= count + CW'(1);
      else if (do_rd && !do_wr) count <= count - CW'(1);
    end
  end

endmodule

// File: sv/hcodec_back.sv
// ----------------------------------------------------------------------------
// hcodec_back
// Unpacks queued transactions into single results held in an output register.
// ----------------------------------------------------------------------------
module hcodec_back
  import hcodec_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  job_t       job,
  input  logic       job_empty,
  output logic       job_pop,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic       uncorrectable,
  output logic       out_last
);

  logic       out_valid;
  logic       sec_valid;
  logic [7:0] sec_byte;
  logic       sec_last;
  logic       load;

  assign empty   = !out_valid;
  assign load    = !out_valid || pop;
  assign job_pop = load && !sec_valid && !job_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sec_valid <= 1'b0;
    end else if (load) begin
      if (sec_valid) begin
        out_valid <= 1'b1;
        sec_valid <= 1'b0;
      end else if (!job_empty) begin
        out_valid <= 1'b1;
        sec_valid <= job.two;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (sec_valid) begin
        out_byte      <= sec_byte;
        uncorrectable <= 1'b0;
        out_last      <= sec_last;
      end else begin
        out_byte      <= job.byte0;
        uncorrectable <= job.bad0;
        out_last      <= job.last0;
        sec_byte      <= job.byte1;
        sec_last      <= job.last1;
      end
    end
  end

endmodule

// File: sv/hamming_12_8_stream_codec.sv
// ----------------------------------------------------------------------------
// hamming_12_8_stream_codec
// Byte-stream Hamming(12,8) encoder/decoder with queue-style ports.
// ----------------------------------------------------------------------------
// Usage:
//   Input side: drive in_byte/in_last with push; a transaction is taken when
//   push is high and full is low. Output side: while empty is low the oldest
//   result sits on out_byte/uncorrectable/out_last; pop takes it.
//   direction_we with direction selects encode (0) or decode (1) and restarts
//   the packing phase; write it only while the codec is idle.
// Timing:
//   A result passes from the front part through the transaction queue into the
//   output register. The front part takes one byte per cycle while the
//   transaction queue (QUEUE_DEPTH entries) has room. The output register
//   delivers one result per cycle while pop is high and results are queued;
//   encoding gives three code bytes per two data bytes and decoding gives two
//   results per three input bytes.
// Reset and stall:
//   rst clears direction to encode, the packing phase, the queue and the
//   output register. When pop is held low the queue fills and full rises;
//   no transaction is lost or repeated.
// ----------------------------------------------------------------------------
module hamming_12_8_stream_codec
  import hcodec_pkg::*;
#(
  parameter int QUEUE_DEPTH = HC_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       direction_we,
  input  logic       direction,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       uncorrectable,
  output logic       out_last
);

  logic accept;
  logic job_push;
  job_t job_in;
  job_t job_out;
  logic job_pop;
  logic job_empty;

  assign accept = push && !full;

  hcodec_front u_front (
    .clk            (clk),
    .rst            (rst),
    .direction_we   (direction_we),
    .direction_data (direction),
    .accept         (accept),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .job_push       (job_push),
    .job            (job_in)
  );

  hcodec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (job_push),
    .wr_job (job_in),
    .rd_en  (job_pop),
    .rd_job (job_out),
    .full   (full),
    .empty  (job_empty)
  );

  hcodec_back u_back (
    .clk           (clk),
    .rst           (rst),
    .job           (job_out),
    .job_empty     (job_empty),
    .job_pop       (job_pop),
    .pop           (pop),
    .empty         (empty),
    .out_byte      (out_byte),
    .uncorrectable (uncorrectable),
    .out_last      (out_last)
  );

endmodule
